// ----- src/wip_pkg.sv -----
// wave interference pixel package: fsm states, register map, sine table entry function
// no dependencies; used by wave_interference_pixel and tb_top
package wip_pkg;

	// pi in q30, used to place the quarter-wave table samples
	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	typedef enum logic [2:0] {
		REG_GRID_WIDTH     = 3'd0,
		REG_SOURCE_COUNT   = 3'd1,
		REG_SOURCE_SPACING = 3'd2,
		REG_WAVE_NUMBER    = 3'd3,
		REG_PHASE_STEP     = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OFFSET,
		ST_SQ_X,
		ST_SQ_Y,
		ST_ROOT_GO,
		ST_ROOT,
		ST_PHASE,
		ST_SINE,
		ST_LOOK,
		ST_DIV_GO,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	// q14 sine of a q30 angle in [0, pi/2], taylor series, rounded
	function automatic logic [14:0] sine_q14(input logic [63:0] th);
		logic [63:0] th2;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] s;
		logic [63:0] v;
		th2  = (th * th) >> 30;
		term = th;
		pos  = th;
		neg  = 64'd0;
		for (int k = 1; k < 20; k++) begin
			if (term != 64'd0) begin
				term = ((term * th2) >> 30) / 64'((2 * k) * (2 * k + 1));
				if (k[0]) begin
					neg = neg + term;
				end else begin
					pos = pos + term;
				end
			end
		end
		s = (pos > neg) ? pos - neg : 64'd0;
		v = (s + 64'd32768) >> 16;
		if (v > 64'd16384) begin
			v = 64'd16384;
		end
		return v[14:0];
	endfunction

endpackage

// ----- src/wip_sqrt.sv -----
// iterative integer square root, one root bit per cycle
// depends on nothing outside this file
module wip_sqrt #(
	parameter int RAD_W = 36
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [RAD_W-1:0]     radicand,
	output logic                 done,
	output logic [RAD_W/2-1:0]   root
);
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int CNT_W  = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0] step_q;
	logic busy_q;
	logic done_q;
	logic [REM_W-1:0] shifted;
	logic [REM_W-1:0] trial;
	logic fits;

	always_comb begin
		shifted = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
		trial   = {root_q, 2'b01};
		fits    = (shifted >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + CNT_W'(1);
				if (step_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= shifted - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= shifted;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- src/wave_interference_pixel.sv -----
// wave interference pixel, top level: apb registers, sequencer, shared multiplier, divider
// depends on wip_pkg and wip_sqrt
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  op, x_coord, y_coord
//   output    out        out_valid/out_stall  amplitude
//   config    apb        psel, penable        paddr, pwdata, prdata
//
// a tick beat is taken whenever the block is idle
// a pixel beat works through each source in turn (offset, squares, root unit,
//   phase, sine lookup) and ends in the bit-serial divide by the source count
// one item is in work at a time; in_stall is high while a pixel is in work
// the finished amplitude sits in an output register, so a new beat is taken
//   while it waits on out_stall
// reset clears control state and loads the register reset values
module wave_interference_pixel #(
	parameter int GRID_MAX     = 1024,
	parameter int MAX_SOURCES  = 8,
	parameter int SINE_ENTRIES = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [4:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         op,
	input  logic [$clog2(GRID_MAX)-1:0]  x_coord,
	input  logic [$clog2(GRID_MAX)-1:0]  y_coord,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [15:0]                  amplitude
);
	import wip_pkg::*;

	localparam int COORD_W = $clog2(GRID_MAX);
	// largest source offset from the centre
	localparam int OFF_MAX = ((MAX_SOURCES + 1) / 2) * 2047 / 2;
	localparam int OFF_W   = $clog2(OFF_MAX + 1);
	// centre reaches 1023 at most, the pixel column GRID_MAX - 1
	localparam int DX_W    = $clog2(GRID_MAX + 1024 + OFF_MAX) + 1;
	localparam int MUL_W   = (DX_W > 17) ? DX_W : 17;
	localparam int D2_W    = 2 * DX_W;
	localparam int RAD_W   = D2_W + 8;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int SRC_W   = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int CNT_W   = $clog2(MAX_SOURCES + 1);
	localparam int SUM_W   = 16 + CNT_W;
	localparam int DIV_CW  = $clog2(SUM_W + 1);
	localparam int IDX_W   = $clog2(SINE_ENTRIES + 1);
	localparam int JP_W    = 14 + IDX_W;

	// configuration registers
	logic [10:0] grid_width_q;
	logic [3:0]  source_count_q;
	logic [10:0] source_spacing_q;
	logic [15:0] wave_number_q;
	logic [15:0] phase_step_q;
	logic [15:0] time_phase_q;

	logic cfg_wr;
	reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q     <= 11'd512;
			source_count_q   <= 4'd2;
			source_spacing_q <= 11'd100;
			wave_number_q    <= 16'd1043;
			phase_step_q     <= 16'd5215;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_GRID_WIDTH:     grid_width_q     <= pwdata[10:0];
				REG_SOURCE_COUNT:   source_count_q   <= pwdata[3:0];
				REG_SOURCE_SPACING: source_spacing_q <= pwdata[10:0];
				REG_WAVE_NUMBER:    wave_number_q    <= pwdata[15:0];
				REG_PHASE_STEP:     phase_step_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_GRID_WIDTH:     prdata = {21'd0, grid_width_q};
			REG_SOURCE_COUNT:   prdata = {28'd0, source_count_q};
			REG_SOURCE_SPACING: prdata = {21'd0, source_spacing_q};
			REG_WAVE_NUMBER:    prdata = {16'd0, wave_number_q};
			REG_PHASE_STEP:     prdata = {16'd0, phase_step_q};
			default:            prdata = 32'd0;
		endcase
	end

	// quarter-wave sine table, constants built at elaboration
	logic [14:0] sine_tab [SINE_ENTRIES+1];
	for (genvar gi = 0; gi <= SINE_ENTRIES; gi++) begin : g_tab
		assign sine_tab[gi] = sine_q14((PI_Q30 * 64'(gi)) / 64'(2 * SINE_ENTRIES));
	end

	// sequencer state
	state_t state_q, state_d;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [SRC_W-1:0]   src_q;
	logic [CNT_W-1:0]   cnt_q;
	logic signed [DX_W-1:0] dx_q;
	logic [D2_W-1:0]    d2_q;
	logic signed [2*MUL_W-1:0] mul_q;
	logic [15:0]        dist_q;
	logic [15:0]        ph_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0]   quo_q;
	logic [CNT_W-1:0]   rem_q;
	logic               neg_q;
	logic [DIV_CW-1:0]  div_step_q;
	logic               out_valid_q;
	logic [15:0]        amplitude_q;

	logic in_take;
	logic out_free;
	logic last_src;
	logic [CNT_W-1:0] cnt_sat;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign out_valid = out_valid_q;
	assign amplitude = amplitude_q;
	assign last_src  = (CNT_W'(src_q) + CNT_W'(1)) == cnt_q;

	// saturate the active source count to one .. MAX_SOURCES
	always_comb begin
		if (source_count_q == 4'd0) begin
			cnt_sat = CNT_W'(1);
		end else if (32'(source_count_q) > MAX_SOURCES) begin
			cnt_sat = CNT_W'(MAX_SOURCES);
		end else begin
			cnt_sat = CNT_W'(source_count_q);
		end
	end

	// source column and its offset from the centre
	logic [OFF_W+10:0] off_prod;
	logic [OFF_W-1:0]  off;
	logic signed [DX_W-1:0] centre_s;
	logic signed [DX_W-1:0] col;
	always_comb begin
		off_prod = (OFF_W + 11)'(src_q >> 1) + (OFF_W + 11)'(1);
		off_prod = off_prod * (OFF_W + 11)'(source_spacing_q);
		off      = off_prod[OFF_W:1];
		centre_s = DX_W'(grid_width_q[10:1]);
		col      = src_q[0] ? centre_s + DX_W'(off) : centre_s - DX_W'(off);
	end

	// shared multiplier, operands picked by the sequencer
	logic signed [MUL_W-1:0] mul_a;
	logic signed [MUL_W-1:0] mul_b;
	always_comb begin
		case (state_q)
			ST_SQ_X: begin
				mul_a = MUL_W'(dx_q);
				mul_b = MUL_W'(dx_q);
			end
			ST_SQ_Y: begin
				mul_a = MUL_W'(y_q);
				mul_b = MUL_W'(y_q);
			end
			ST_PHASE: begin
				mul_a = MUL_W'(signed'(wave_number_q));
				mul_b = MUL_W'(dist_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// root unit
	logic sqrt_start;
	logic sqrt_done;
	logic [ROOT_W-1:0] sqrt_root;
	logic [D2_W-1:0] d2_sum;
	logic [ROOT_W+15:0] root_ext;

	assign sqrt_start = (state_q == ST_ROOT_GO);
	assign d2_sum     = d2_q + mul_q[D2_W-1:0];
	assign root_ext   = {16'd0, sqrt_root};

	wip_sqrt #(
		.RAD_W(RAD_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({d2_sum, 8'd0}),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// sine lookup: quadrant folds the table index and the sign
	logic [JP_W-1:0]  j_prod;
	logic [IDX_W-1:0] j_idx;
	logic [IDX_W-1:0] tab_idx;
	logic signed [SUM_W-1:0] sine_val;
	always_comb begin
		j_prod  = JP_W'(ph_q[13:0]) * JP_W'(SINE_ENTRIES);
		j_idx   = j_prod[JP_W-1:14];
		tab_idx = ph_q[14] ? IDX_W'(SINE_ENTRIES) - j_idx : j_idx;
		sine_val = SUM_W'(sine_tab[tab_idx]);
		if (ph_q[15]) begin
			sine_val = -sine_val;
		end
	end

	// divide step, restoring
	logic [CNT_W:0] div_trial;
	logic div_fits;
	assign div_trial = {rem_q, quo_q[SUM_W-1]};
	assign div_fits  = (div_trial >= (CNT_W + 1)'(cnt_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take && op) begin
					state_d = ST_OFFSET;
				end
			end
			ST_OFFSET:  state_d = ST_SQ_X;
			ST_SQ_X:    state_d = ST_SQ_Y;
			ST_SQ_Y:    state_d = ST_ROOT_GO;
			ST_ROOT_GO: state_d = ST_ROOT;
			ST_ROOT: begin
				if (sqrt_done) begin
					state_d = ST_PHASE;
				end
			end
			ST_PHASE:   state_d = ST_SINE;
			ST_SINE:    state_d = ST_LOOK;
			ST_LOOK:    state_d = last_src ? ST_DIV_GO : ST_OFFSET;
			ST_DIV_GO:  state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (div_step_q == DIV_CW'(SUM_W - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			time_phase_q <= 16'd0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_take && !op) begin
				time_phase_q <= time_phase_q + phase_step_q;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		case (state_q)
			ST_IDLE: begin
				x_q   <= x_coord;
				y_q   <= y_coord;
				src_q <= '0;
				cnt_q <= cnt_sat;
				sum_q <= '0;
			end
			ST_OFFSET: dx_q <= col - DX_W'(x_q);
			ST_SQ_Y:   d2_q <= mul_q[D2_W-1:0];
			ST_ROOT: begin
				dist_q <= (root_ext > (ROOT_W + 16)'(65535)) ? 16'hFFFF : root_ext[15:0];
			end
			ST_SINE:   ph_q <= mul_q[19:4] - time_phase_q;
			ST_LOOK: begin
				sum_q <= sum_q + sine_val;
				src_q <= src_q + SRC_W'(1);
			end
			ST_DIV_GO: begin
				neg_q      <= sum_q[SUM_W-1];
				quo_q      <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
				rem_q      <= '0;
				div_step_q <= '0;
			end
			ST_DIVIDE: begin
				div_step_q <= div_step_q + DIV_CW'(1);
				quo_q <= {quo_q[SUM_W-2:0], div_fits};
				rem_q <= div_fits ? CNT_W'(div_trial - (CNT_W + 1)'(cnt_q))
					: CNT_W'(div_trial);
			end
			ST_DONE: begin
				if (out_free) begin
					amplitude_q <= neg_q ? 16'(-quo_q) : quo_q[15:0];
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- src/wip_check.sv -----
// port-level checks for wave_interference_pixel, with the bind that attaches them
// depends on wave_interference_pixel port names
module wip_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        op,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] amplitude
);

	// a held result beat stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(amplitude))
		else $error("output beat dropped or changed while stalled");

	// a pixel beat occupies the block on the next cycle
	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && op |=> in_stall)
		else $error("block free right after a pixel beat");

	// a tick beat leaves the block free
	a_tick_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !op |=> !in_stall)
		else $error("block busy after a tick beat");

	// the mean of sines stays within plus or minus one
	a_amp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(amplitude) >= -16'sd16384) &&
			($signed(amplitude) <= 16'sd16384))
		else $error("amplitude outside plus or minus one");

endmodule

bind wave_interference_pixel wip_check u_wip_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.op        (op),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.amplitude (amplitude)
);

// ----- verif/tb_top.sv -----
// testbench for wave_interference_pixel: apb register phases, random pixel and tick beats
// depends on wip_pkg (register indexes) and the rtl under src
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import wip_pkg::*;

	localparam int N_TAB = 256;
	localparam int N_SRC_MAX = 8;

	// scoreboard: own copy of registers and time phase, queue of expected amplitudes
	class amp_scoreboard;
		int tab[0:N_TAB];
		int unsigned width_r, count_r, spacing_r;
		logic [15:0] wavenum_r, step_r, phase_r;
		logic [15:0] amp_q[$];
		int errors;

		function new();
			longint unsigned th;
			for (int i = 0; i <= N_TAB; i++) begin
				th = (64'd3373259426 * i) / (2 * N_TAB);
				tab[i] = taylor_q14(th);
			end
			width_r = 512; count_r = 2; spacing_r = 100;
			wavenum_r = 16'd1043; step_r = 16'd5215; phase_r = 0;
			errors = 0;
		endfunction

		function int taylor_q14(longint unsigned th);
			longint unsigned th2, term, pos, neg, s, v;
			th2 = (th * th) >> 30;
			term = th; pos = th; neg = 0;
			for (int k = 1; k < 20 && term != 0; k++) begin
				term = ((term * th2) >> 30) / ((2 * k) * (2 * k + 1));
				if (k & 1) neg += term;
				else pos += term;
			end
			s = (pos > neg) ? pos - neg : 0;
			v = (s + 64'd32768) >> 16;
			if (v > 16384) v = 16384;
			return int'(v);
		endfunction

		function longint unsigned int_root(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] val);
			case (idx)
				REG_GRID_WIDTH: width_r = val[10:0];
				REG_SOURCE_COUNT: count_r = val[3:0];
				REG_SOURCE_SPACING: spacing_r = val[10:0];
				REG_WAVE_NUMBER: wavenum_r = val[15:0];
				REG_PHASE_STEP: step_r = val[15:0];
				default: ;
			endcase
		endfunction

		function void note_beat(logic op, logic [9:0] x, logic [9:0] y);
			longint cnt, sum, centre, off, c, dx, d2, root_d, prod;
			logic [15:0] ph;
			int j, v;
			if (!op) begin
				phase_r = phase_r + step_r;
				return;
			end
			cnt = count_r;
			if (cnt < 1) cnt = 1;
			if (cnt > N_SRC_MAX) cnt = N_SRC_MAX;
			centre = width_r / 2;
			sum = 0;
			for (longint q = 0; q < cnt; q++) begin
				off = (((q / 2) + 1) * longint'(spacing_r)) / 2;
				c = q[0] ? centre + off : centre - off;
				dx = c - longint'(x);
				d2 = dx * dx + longint'(y) * longint'(y);
				root_d = longint'(int_root(longint'(d2) << 8));
				if (root_d > 65535) root_d = 65535;
				prod = longint'($signed(wavenum_r)) * root_d;
				ph = 16'(prod >>> 4) - phase_r;
				j = (int'(ph[13:0]) * N_TAB) >> 14;
				v = ph[14] ? tab[N_TAB - j] : tab[j];
				sum += ph[15] ? -v : v;
			end
			amp_q = {amp_q, 16'(sum / cnt)};
		endfunction

		function void check_amp(logic [15:0] got);
			logic [15:0] exp_amp;
			if (amp_q.size() == 0) begin
				report_mismatch($sformatf("amplitude %0d with nothing expected", $signed(got)));
				return;
			end
			exp_amp = amp_q.pop_front();
			if (got !== exp_amp)
				report_mismatch($sformatf("amplitude %0d expected %0d",
					$signed(got), $signed(exp_amp)));
		endfunction

		function void report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_stall, op;
	logic [9:0] x_coord, y_coord;
	logic out_valid, out_stall;
	logic [15:0] amplitude;

	wave_interference_pixel dut (.*);

	amp_scoreboard sb = new();

	// idle rates in percent, changed per phase
	int send_idle = 0, recv_idle = 0;
	// long receiver hold-off, counted in its own process
	int hold_cycles = 0;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// generous fixed limit on the whole run
	initial begin
		#3ms;
		$display("Test completed with failures");
		$finish;
	end

	// receiver: stall at random or through a hold-off, check each result beat
	initial begin
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_amp(amplitude);
	end

	// apb write: setup then access, register taken at the access edge
	task automatic write_register(reg_idx_t idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= 5'(4 * int'(idx)); pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// one input beat, held until accepted
	task automatic send_beat(logic o, logic [9:0] x, logic [9:0] y);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1; op <= o; x_coord <= x; y_coord <= y;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_beat(o, x, y);
		@(negedge clk);
	endtask

	task automatic go_idle();
		in_valid <= 0;
		while (sb.amp_q.size() != 0) @(negedge clk);
		// a trailing tick is already taken; this only pads the gap
		repeat (100) @(negedge clk);
	endtask

	task automatic random_beats(int n);
		logic [9:0] x, y;
		for (int i = 0; i < n; i++) begin
			x = $urandom_range(3) == 0 ? ($urandom_range(1) ? 10'd1023 : 10'd0) : 10'($urandom);
			y = $urandom_range(3) == 0 ? 10'($urandom_range(15)) : 10'($urandom);
			send_beat($urandom_range(99) < 70, x, y);
		end
	endtask

	initial begin
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; op = 0; x_coord = 0; y_coord = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reset values, field extremes, ticks around the phase wrap
		send_beat(1, 10'd0, 10'd0);
		send_beat(1, 10'd1023, 10'd1023);
		send_beat(1, 10'd256, 10'd0);
		send_beat(0, 10'd0, 10'd0);
		send_beat(1, 10'd512, 10'd100);
		for (int i = 0; i < 13; i++) send_beat(0, 10'h3ff, 10'h3ff);
		send_beat(1, 10'd300, 10'd5);
		go_idle();
		// count zero acts as one, width zero puts centre at 0
		write_register(REG_SOURCE_COUNT, 32'd0);
		write_register(REG_GRID_WIDTH, 32'd0);
		write_register(REG_SOURCE_SPACING, 32'd2047);
		write_register(REG_WAVE_NUMBER, 32'h8000);
		write_register(REG_PHASE_STEP, 32'h7fff);
		send_beat(1, 10'd1023, 10'd1023);
		send_beat(0, 0, 0);
		send_beat(1, 10'd0, 10'd0);
		go_idle();
		// count above the limit saturates, sources far off the grid
		write_register(REG_SOURCE_COUNT, 32'd15);
		write_register(REG_GRID_WIDTH, 32'd1024);
		write_register(REG_WAVE_NUMBER, 32'h7fff);
		write_register(REG_PHASE_STEP, 32'h8000);
		send_beat(1, 10'd1023, 10'd0);
		send_beat(1, 10'd0, 10'd1023);
		go_idle();

		// random phases under varied settings and idling
		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: begin send_idle = 12; recv_idle = 78; end
				1: begin send_idle = 78; recv_idle = 12; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			write_register(REG_GRID_WIDTH, ph == 5 ? 32'd2047 : $urandom_range(2047));
			write_register(REG_SOURCE_COUNT, ph == 4 ? 32'd8 : $urandom_range(15));
			write_register(REG_SOURCE_SPACING, ph == 3 ? 32'd0 : $urandom_range(2047));
			write_register(REG_WAVE_NUMBER, $urandom_range(65535));
			write_register(REG_PHASE_STEP, $urandom_range(65535));
			if (ph == 2) begin
				// receiver holds off while beats keep coming, so input stalls
				hold_cycles = 400;
			end
			random_beats(250);
			go_idle();
		end

		send_idle = 0; recv_idle = 0;
		go_idle();
		if (sb.errors == 0 && sb.amp_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
